// ----- rtl/fcar_pkg.sv -----
// shared constants, types and character helpers for the command link block
package fcar_pkg;

  // receive store and sample sizing
  localparam int RX_DEPTH    = 32;
  localparam int RX_AW       = $clog2(RX_DEPTH);
  localparam int SAMPLE_BITS = 12;
  localparam int S_DATA_BITS = ((8 + SAMPLE_BITS + 7) / 8) * 8;

  // latched sample holds at most four decimal digits
  localparam int HELD_BITS = 14;
  localparam int CMP_BITS  = (SAMPLE_BITS > HELD_BITS) ? SAMPLE_BITS : HELD_BITS;
  localparam logic [CMP_BITS-1:0] SAT_MAX = CMP_BITS'(9999);
  localparam int DIGITS    = 4;
  localparam int BCD_BITS  = 4 * DIGITS;
  localparam int DD_STEPS  = HELD_BITS / 2;
  localparam int DD_CW     = $clog2(DD_STEPS + 1);

  // message layout
  localparam int PREFIX_LEN = 7;
  localparam int IDX_BITS   = 4;

  // timeout register
  localparam int TMR_BITS = 16;
  localparam logic [TMR_BITS-1:0] TIMEOUT_RESET = 16'd3000;
  localparam int ADDR_BITS = 3;
  localparam logic [ADDR_BITS-1:0] ADDR_TIMEOUT = 3'd0;

  // characters
  localparam logic [7:0] CH_START = 8'h21;
  localparam logic [7:0] CH_END   = 8'h23;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_O     = 8'h4F;
  localparam logic [7:0] CH_K     = 8'h4B;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  // operation codes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // commands from the controller to the datapath
  typedef struct packed {
    logic step;
    logic load;
  } fcar_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic report_go;
    logic byte_ready;
    logic byte_last;
  } fcar_stat_t;

  // fixed text CR LF "!ADC="
  function automatic logic [7:0] prefix_char(input logic [2:0] i);
    logic [7:0] c;
    case (i)
      3'd0:    c = 8'h0D;
      3'd1:    c = 8'h0A;
      3'd2:    c = CH_START;
      3'd3:    c = 8'h41;
      3'd4:    c = 8'h44;
      3'd5:    c = 8'h43;
      3'd6:    c = 8'h3D;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/framed_command_adc_report.sv -----
// top level: command link with ADC report, register port and stream channels
//
//  channel   dir  handshake           payload
//  s_*       in   s_tvalid/s_tready   tdata: rx_byte, adc_sample; tuser: operation
//  m_*       out  m_tvalid/m_tready   tdata: tx_byte; tlast: last
//  apb       in   psel/penable        ack_timeout_ticks: read at 0, written at 0 to 3
//
// an item that starts no report leaves the input ready for the next item;
// a report holds the input until its last byte enters the output register,
// which paces the text while the decimal converter runs beside the prefix.
// rst is synchronous and clears the store, link state and timeout to 3000.
// output stalls hold the message; a finished last byte may wait while the
// next item is taken.
module framed_command_adc_report (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [fcar_pkg::S_DATA_BITS-1:0]      s_tdata,  // rx_byte, adc_sample
  input  logic                                  s_tuser,  // operation
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [7:0]                            m_tdata,  // tx_byte
  output logic                                  m_tlast,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [fcar_pkg::ADDR_BITS-1:0]        paddr,
  input  logic [31:0]                           pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready
);
  import fcar_pkg::*;

  logic [TMR_BITS-1:0] ack_timeout_ticks;
  fcar_cmd_t           cmd;
  fcar_stat_t          stat;

  // register port
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_TIMEOUT) ? {16'd0, ack_timeout_ticks} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      ack_timeout_ticks <= TIMEOUT_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == ADDR_TIMEOUT[2]) begin
      ack_timeout_ticks <= pwdata[TMR_BITS-1:0];
    end
  end

  // controller
  fcar_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath
  fcar_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .s_tdata           (s_tdata),
    .s_tuser           (s_tuser),
    .ack_timeout_ticks (ack_timeout_ticks),
    .cmd               (cmd),
    .stat              (stat),
    .m_tdata           (m_tdata),
    .m_tlast           (m_tlast)
  );

endmodule

// ----- rtl/fcar_ctrl.sv -----
// controller: accepts items and paces message bytes into the output register
module fcar_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  output logic               m_tvalid,
  input  logic               m_tready,
  input  fcar_pkg::fcar_stat_t stat,
  output fcar_pkg::fcar_cmd_t  cmd
);
  import fcar_pkg::*;

  typedef enum logic {ST_IDLE, ST_SEND} state_t;
  state_t state;

  // input is taken only while no message is being sent
  assign s_tready = (state == ST_IDLE);

  // command decode
  always_comb begin
    cmd.step = s_tvalid && s_tready;
    cmd.load = (state == ST_SEND) && stat.byte_ready && (!m_tvalid || m_tready);
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (cmd.step && stat.report_go) begin
            state <= ST_SEND;
          end
        end
        ST_SEND: begin
          if (cmd.load && stat.byte_last) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/fcar_dp.sv -----
// datapath: receive store, frame parser, ack timer, decimal converter, byte mux
module fcar_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [fcar_pkg::S_DATA_BITS-1:0]     s_tdata,
  input  logic                                 s_tuser,
  input  logic [fcar_pkg::TMR_BITS-1:0]        ack_timeout_ticks,
  input  fcar_pkg::fcar_cmd_t                  cmd,
  output fcar_pkg::fcar_stat_t                 stat,
  output logic [7:0]                           m_tdata,
  output logic                                 m_tlast
);
  import fcar_pkg::*;

  logic [7:0]             rx_store [RX_DEPTH];
  logic [RX_AW-1:0]       rx_position;
  logic                   parser_in_frame;
  logic                   link_waiting_ack;
  logic                   cmd_pending;
  logic                   cmd_is_ok;
  logic [HELD_BITS-1:0]   held_sample;
  logic [TMR_BITS-1:0]    ack_timer;
  logic [HELD_BITS-1:0]   dd_bin;
  logic [BCD_BITS-1:0]    dd_bcd;
  logic [DD_CW-1:0]       dd_cnt;
  logic [IDX_BITS-1:0]    msg_idx;

  logic [7:0]             rx_byte;
  logic [SAMPLE_BITS-1:0] adc_sample;
  logic                   is_byte;
  logic [RX_AW-1:0]       pos_inc;
  logic [7:0]             st0, st1, st2, st3;
  logic                   rst_match, ok_match;
  logic [RX_AW-1:0]       rx_position_next;
  logic                   parser_in_frame_next;
  logic                   cmd_pending_next;
  logic                   cmd_is_ok_next;
  logic                   link_waiting_ack_next;
  logic [HELD_BITS-1:0]   held_sample_next;
  logic [TMR_BITS-1:0]    ack_timer_next;
  logic                   expired;
  logic                   emit;
  logic [CMP_BITS-1:0]    sample_wide;
  logic [BCD_BITS-1:0]    dd_bcd_next;
  logic [HELD_BITS-1:0]   dd_bin_next;
  logic [2:0]             ndig;
  logic [IDX_BITS-1:0]    dig_pos;
  logic [1:0]             dig_sel;
  logic [3:0]             dig_val;
  logic [7:0]             msg_char;
  logic                   msg_last;

  assign rx_byte    = s_tdata[7:0];
  assign adc_sample = s_tdata[8 +: SAMPLE_BITS];
  assign is_byte    = (s_tuser == OP_BYTE);
  assign pos_inc    = (rx_position == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_position + 1'b1;

  // store contents as seen after this byte is written
  always_comb begin
    st0 = (is_byte && rx_position == RX_AW'(0)) ? rx_byte : rx_store[0];
    st1 = (is_byte && rx_position == RX_AW'(1)) ? rx_byte : rx_store[1];
    st2 = (is_byte && rx_position == RX_AW'(2)) ? rx_byte : rx_store[2];
    st3 = (is_byte && rx_position == RX_AW'(3)) ? rx_byte : rx_store[3];
    rst_match = (st0 == CH_R) && (st1 == CH_S) && (st2 == CH_T) && (st3 == CH_END);
    ok_match  = (st0 == CH_O) && (st1 == CH_K) && (st2 == CH_END);
  end

  // parser, timer and link decisions for one transaction
  always_comb begin
    rx_position_next      = rx_position;
    parser_in_frame_next  = parser_in_frame;
    cmd_pending_next      = cmd_pending;
    cmd_is_ok_next        = cmd_is_ok;
    link_waiting_ack_next = link_waiting_ack;
    held_sample_next      = held_sample;
    ack_timer_next        = ack_timer;
    expired               = 1'b0;
    emit                  = 1'b0;
    sample_wide           = CMP_BITS'(adc_sample);

    if (is_byte) begin
      rx_position_next = pos_inc;
      if (!parser_in_frame) begin
        if (rx_byte == CH_START) begin
          rx_position_next     = '0;
          parser_in_frame_next = 1'b1;
        end
      end else if (rx_byte == CH_END) begin
        if (rst_match) begin
          cmd_is_ok_next   = 1'b0;
          cmd_pending_next = 1'b1;
        end
        if (ok_match) begin
          cmd_is_ok_next   = 1'b1;
          cmd_pending_next = 1'b1;
        end
        parser_in_frame_next = 1'b0;
      end
    end else if (link_waiting_ack) begin
      if (ack_timer <= TMR_BITS'(1)) begin
        ack_timer_next = '0;
        expired        = 1'b1;
      end else begin
        ack_timer_next = ack_timer - 1'b1;
      end
    end

    if (!link_waiting_ack) begin
      if (cmd_pending_next && !cmd_is_ok_next) begin
        held_sample_next      = (sample_wide > SAT_MAX) ? HELD_BITS'(SAT_MAX)
                                                        : HELD_BITS'(sample_wide);
        cmd_pending_next      = 1'b0;
        link_waiting_ack_next = 1'b1;
        emit                  = 1'b1;
      end
    end else begin
      if (cmd_pending_next && cmd_is_ok_next) begin
        cmd_pending_next      = 1'b0;
        link_waiting_ack_next = 1'b0;
      end
      if (expired) begin
        link_waiting_ack_next = 1'b1;
        emit                  = 1'b1;
      end
    end
    if (emit) begin
      ack_timer_next = ack_timeout_ticks;
    end
  end

  // receive store write
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < RX_DEPTH; i++) begin
        rx_store[i] <= '0;
      end
    end else if (cmd.step && is_byte) begin
      rx_store[rx_position] <= rx_byte;
    end
  end

  // link and parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      rx_position      <= '0;
      parser_in_frame  <= 1'b0;
      link_waiting_ack <= 1'b0;
      cmd_pending      <= 1'b0;
      cmd_is_ok        <= 1'b0;
      held_sample      <= '0;
      ack_timer        <= '0;
    end else if (cmd.step) begin
      rx_position      <= rx_position_next;
      parser_in_frame  <= parser_in_frame_next;
      link_waiting_ack <= link_waiting_ack_next;
      cmd_pending      <= cmd_pending_next;
      cmd_is_ok        <= cmd_is_ok_next;
      held_sample      <= held_sample_next;
      ack_timer        <= ack_timer_next;
    end
  end

  // double dabble, two bits per cycle
  always_comb begin
    dd_bcd_next = dd_bcd;
    dd_bin_next = dd_bin;
    for (int k = 0; k < 2; k++) begin
      for (int d = 0; d < DIGITS; d++) begin
        if (dd_bcd_next[4*d +: 4] >= 4'd5) begin
          dd_bcd_next[4*d +: 4] = dd_bcd_next[4*d +: 4] + 4'd3;
        end
      end
      dd_bcd_next = {dd_bcd_next[BCD_BITS-2:0], dd_bin_next[HELD_BITS-1]};
      dd_bin_next = {dd_bin_next[HELD_BITS-2:0], 1'b0};
    end
  end

  // converter control
  always_ff @(posedge clk) begin
    if (rst) begin
      dd_cnt <= '0;
      dd_bcd <= '0;
      dd_bin <= '0;
    end else if (cmd.step && emit) begin
      dd_cnt <= DD_CW'(DD_STEPS);
      dd_bcd <= '0;
      dd_bin <= held_sample_next;
    end else if (dd_cnt != '0) begin
      dd_cnt <= dd_cnt - 1'b1;
      dd_bcd <= dd_bcd_next;
      dd_bin <= dd_bin_next;
    end
  end

  // digit count without leading zeros
  always_comb begin
    if (dd_bcd[15:12] != 4'd0) begin
      ndig = 3'd4;
    end else if (dd_bcd[11:8] != 4'd0) begin
      ndig = 3'd3;
    end else if (dd_bcd[7:4] != 4'd0) begin
      ndig = 3'd2;
    end else begin
      ndig = 3'd1;
    end
  end

  // message byte select
  always_comb begin
    dig_pos  = msg_idx - IDX_BITS'(PREFIX_LEN);
    dig_sel  = 2'(ndig - 3'd1 - 3'(dig_pos));
    dig_val  = dd_bcd[4*dig_sel +: 4];
    msg_last = 1'b0;
    if (msg_idx < IDX_BITS'(PREFIX_LEN)) begin
      msg_char = prefix_char(msg_idx[2:0]);
    end else if (msg_idx < IDX_BITS'(PREFIX_LEN) + IDX_BITS'(ndig)) begin
      msg_char = CH_ZERO + 8'(dig_val);
    end else begin
      msg_char = CH_END;
      msg_last = 1'b1;
    end
  end

  // status to the controller
  always_comb begin
    stat.report_go  = emit;
    stat.byte_ready = (msg_idx < IDX_BITS'(PREFIX_LEN)) || (dd_cnt == '0);
    stat.byte_last  = msg_last;
  end

  // byte counter and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      msg_idx <= '0;
    end else if (cmd.step && emit) begin
      msg_idx <= '0;
    end else if (cmd.load) begin
      msg_idx <= msg_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      m_tdata <= msg_char;
      m_tlast <= msg_last;
    end
  end

endmodule
